// File: src/kabf_pkg.sv
// Shared types, constants and helpers for the angle/bias Kalman filter.
// No dependencies.
package kabf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [15:0] RST_PERIOD        = 16'd524;
    localparam logic [30:0] RST_ANGLE_NOISE   = 31'd655;
    localparam logic [30:0] RST_BIAS_NOISE    = 31'd655;
    localparam logic [30:0] RST_MEASURE_NOISE = 31'd655;
    localparam logic [31:0] RST_INITIAL_BIAS  = 32'd6554;

    // Configuration register indexes
    localparam logic [2:0] REG_PERIOD  = 3'd0;
    localparam logic [2:0] REG_ANOISE  = 3'd1;
    localparam logic [2:0] REG_BNOISE  = 3'd2;
    localparam logic [2:0] REG_MNOISE  = 3'd3;
    localparam logic [2:0] REG_IBIAS   = 3'd4;

    // Datapath operations, one per sequencer step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,    // latch inputs
        OP_M_GDT,   // m0 = mul(g,dt)
        OP_M_BDT,   // m1 = mul(bias,dt)
        OP_ANG,     // angle = sat(angle + m0 - m1)
        OP_M_BBDT,  // m0 = mul(cov_bb,dt)
        OP_T,       // t = sat(m0 - cov_ab); p01, p10, p11
        OP_M_BADT,  // m1 = mul(cov_ba,dt)
        OP_M_TDT,   // m2 = mul(t,dt)
        OP_P00,     // p00, s, e
        OP_DIV0,    // start k0 division
        OP_DIV1,    // start k1 division
        OP_K0,      // store k0
        OP_K1,      // store k1
        OP_M_K0E,   // m0 = mul(k0,e)
        OP_M_K1E,   // m1 = mul(k1,e)
        OP_CORR,    // angle, bias update
        OP_RATE,    // rate
        OP_M_K0P00, // m0
        OP_M_K0P01, // m1
        OP_M_K1P00, // m2
        OP_M_K1P01, // m3
        OP_COV      // covariance update
    } t_op;

    typedef struct packed {
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_status;

    // Saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: src/kabf_div.sv
// Restoring divider, one quotient bit per cycle, signed truncating.
// Depends on kabf_pkg.
module kabf_div
    import kabf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_num,
    input  logic signed [33:0]  i_den,
    output logic                o_busy,
    output logic signed [31:0]  o_quot
);
    localparam int NW = 32 + FRAC_BITS;   // magnitude of numerator scaled
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  r_q, n_q;
    logic [33:0]    r_rem, n_rem;
    logic [33:0]    r_den;
    logic           r_neg;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic [34:0]    w_try;
    logic [NW:0]    w_mag;

    // Shift one bit in, subtract when it fits
    always_comb begin
        w_try = {r_rem, r_q[NW-1]} - {1'b0, r_den};
        if (!w_try[34]) begin
            n_rem = w_try[33:0];
            n_q   = {r_q[NW-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[32:0], r_q[NW-1]};
            n_q   = {r_q[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {(i_num[31] ? NW'(-$signed(i_num)) : NW'(i_num))} << FRAC_BITS;
            r_den <= i_den[33] ? 34'(-i_den) : i_den;
            r_neg <= i_num[31] ^ i_den[33];
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    // Apply sign and saturate
    always_comb begin
        w_mag = {1'b0, r_q};
        if (r_neg) begin
            o_quot = (w_mag > (NW+1)'(33'h8000_0000)) ? 32'sh8000_0000
                                                      : 32'(-$signed(w_mag));
        end else begin
            o_quot = (w_mag > (NW+1)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                      : w_mag[31:0];
        end
    end

    assign o_busy = r_busy;
endmodule

// File: src/kabf_dp.sv
// Datapath: state registers, one shared multiplier, adders and divider.
// Depends on kabf_pkg and kabf_div.
module kabf_dp
    import kabf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic signed [31:0]  i_gyro_rate,
    input  logic signed [31:0]  i_measured_angle,
    output logic signed [31:0]  o_angle_estimate,
    output logic signed [31:0]  o_corrected_rate
);
    logic [15:0] r_dt;
    logic [30:0] r_anoise, r_bnoise, r_mnoise;
    logic signed [31:0] r_angle, r_bias, r_aa, r_ab, r_ba, r_bb;
    logic signed [31:0] r_g, r_meas, r_t, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_k0, r_k1, r_e, r_rate;
    logic signed [31:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [33:0] r_s;
    logic               r_szero;
    logic signed [31:0] w_ma, w_mb, w_mq, w_quot;
    logic signed [63:0] w_prod, w_sh;
    logic               w_div_start, w_div_busy;
    logic signed [31:0] w_dnum;

    // Select multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_M_GDT:   begin w_ma = r_g;    w_mb = $signed({16'd0, r_dt}); end
            OP_M_BDT:   begin w_ma = r_bias; w_mb = $signed({16'd0, r_dt}); end
            OP_M_BBDT:  begin w_ma = r_bb;   w_mb = $signed({16'd0, r_dt}); end
            OP_M_BADT:  begin w_ma = r_ba;   w_mb = $signed({16'd0, r_dt}); end
            OP_M_TDT:   begin w_ma = r_t;    w_mb = $signed({16'd0, r_dt}); end
            OP_M_K0E:   begin w_ma = r_k0;   w_mb = r_e;   end
            OP_M_K1E:   begin w_ma = r_k1;   w_mb = r_e;   end
            OP_M_K0P00: begin w_ma = r_k0;   w_mb = r_p00; end
            OP_M_K0P01: begin w_ma = r_k0;   w_mb = r_p01; end
            OP_M_K1P00: begin w_ma = r_k1;   w_mb = r_p00; end
            OP_M_K1P01: begin w_ma = r_k1;   w_mb = r_p01; end
            default:    begin w_ma = '0;     w_mb = '0;    end
        endcase
    end

    // Floor shift and saturate the product
    assign w_prod = 64'(w_ma) * 64'(w_mb);
    assign w_sh   = w_prod >>> FRAC_BITS;
    assign w_mq   = sat32(w_sh);

    assign w_div_start = (i_cmd.op == OP_DIV0) || (i_cmd.op == OP_DIV1);
    assign w_dnum      = (i_cmd.op == OP_DIV0) ? r_p00 : r_p10;

    kabf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dnum),
        .i_den   (r_s),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Configuration registers and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt     <= RST_PERIOD;
            r_anoise <= RST_ANGLE_NOISE;
            r_bnoise <= RST_BIAS_NOISE;
            r_mnoise <= RST_MEASURE_NOISE;
            r_angle  <= '0;
            r_bias   <= RST_INITIAL_BIAS;
            r_aa     <= 32'sd1 <<< FRAC_BITS;
            r_ab     <= '0;
            r_ba     <= '0;
            r_bb     <= 32'sd1 <<< FRAC_BITS;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PERIOD: r_dt     <= i_cfg_data[15:0];
                    REG_ANOISE: r_anoise <= i_cfg_data[30:0];
                    REG_BNOISE: r_bnoise <= i_cfg_data[30:0];
                    REG_MNOISE: r_mnoise <= i_cfg_data[30:0];
                    REG_IBIAS:  r_bias   <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_ANG:  r_angle <= sat32(64'(r_angle) + 64'(r_m0) - 64'(r_m1));
                OP_CORR: begin
                    r_angle <= sat32(64'(r_angle) + 64'(r_m0));
                    r_bias  <= sat32(64'(r_bias) + 64'(r_m1));
                end
                OP_COV: begin
                    r_aa <= sat32(64'(r_p00) - 64'(r_m0));
                    r_ab <= sat32(64'(r_p01) - 64'(r_m1));
                    r_ba <= sat32(64'(r_p10) - 64'(r_m2));
                    r_bb <= sat32(64'(r_p11) - 64'(r_m3));
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_g    <= i_gyro_rate;
                r_meas <= i_measured_angle;
            end
            OP_M_GDT, OP_M_BBDT, OP_M_K0E, OP_M_K0P00: r_m0 <= w_mq;
            OP_M_BDT, OP_M_BADT, OP_M_K1E, OP_M_K0P01: r_m1 <= w_mq;
            OP_M_TDT, OP_M_K1P00:                      r_m2 <= w_mq;
            OP_M_K1P01:                                r_m3 <= w_mq;
            OP_T: begin
                r_t   <= sat32(64'(r_m0) - 64'(r_ab));
                r_p01 <= sat32(64'(r_ab) - 64'(r_m0));
                r_p10 <= sat32(64'(r_ba) - 64'(r_m0));
                r_p11 <= sat32(64'(r_bb) + 64'(r_bnoise));
            end
            OP_P00: begin
                r_p00 <= sat32(64'(r_aa) - 64'(r_m1) + 64'(r_m2) + 64'(r_anoise));
                r_s   <= 34'(sat32(64'(r_aa) - 64'(r_m1) + 64'(r_m2)
                             + 64'(r_anoise))) + 34'(r_mnoise);
                r_e   <= sat32(64'(r_meas) - 64'(r_angle));
            end
            OP_DIV0: r_szero <= (r_s == '0);
            OP_K0:   r_k0 <= r_szero ? '0 : w_quot;
            OP_K1:   r_k1 <= r_szero ? '0 : w_quot;
            OP_RATE: r_rate <= sat32(64'(r_g) - 64'(r_bias));
            default: ;
        endcase
    end

    assign o_status.div_busy = w_div_busy;
    assign o_angle_estimate  = r_angle;
    assign o_corrected_rate  = r_rate;
endmodule

// File: src/kabf_ctrl.sv
// Sequencer: steps the datapath through predict, gain, correct and update.
// Depends on kabf_pkg.
module kabf_ctrl
    import kabf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_DIV  = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_op    r_step, n_step;
    logic   r_div1, n_div1;

    // Next step after a plain step
    function automatic t_op next_op(input t_op op);
        t_op r;
        case (op)
            OP_LOAD:    r = OP_M_GDT;
            OP_M_GDT:   r = OP_M_BDT;
            OP_M_BDT:   r = OP_ANG;
            OP_ANG:     r = OP_M_BBDT;
            OP_M_BBDT:  r = OP_T;
            OP_T:       r = OP_M_BADT;
            OP_M_BADT:  r = OP_M_TDT;
            OP_M_TDT:   r = OP_P00;
            OP_P00:     r = OP_DIV0;
            OP_K1:      r = OP_M_K0E;
            OP_M_K0E:   r = OP_M_K1E;
            OP_M_K1E:   r = OP_CORR;
            OP_CORR:    r = OP_RATE;
            OP_RATE:    r = OP_M_K0P00;
            OP_M_K0P00: r = OP_M_K0P01;
            OP_M_K0P01: r = OP_M_K1P00;
            OP_M_K1P00: r = OP_M_K1P01;
            OP_M_K1P01: r = OP_COV;
            default:    r = OP_NONE;
        endcase
        return r;
    endfunction

    // Sequence steps; divisions wait on the divider
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_div1    = r_div1;
        o_cmd.op  = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_step   = OP_M_GDT;
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.op = r_step;
                if (r_step == OP_P00) begin
                    n_step = OP_DIV0;
                    n_div1 = 1'b0;
                    n_state = S_DIV;
                end else if (r_step == OP_COV) begin
                    n_state = S_OUT;
                end else begin
                    n_step = next_op(r_step);
                end
            end
            S_DIV: begin
                o_cmd.op = r_div1 ? OP_DIV1 : OP_DIV0;
                n_state  = S_WAIT;
            end
            S_WAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.op = r_div1 ? OP_K1 : OP_K0;
                    if (r_div1) begin
                        n_step  = OP_M_K0E;
                        n_state = S_RUN;
                    end else begin
                        n_div1  = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= OP_NONE;
            r_div1  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_div1  <= n_div1;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
endmodule

// File: src/kalman_angle_bias_filter_core.sv
// Two-state angle/gyro-bias Kalman filter, top level.
// Depends on kabf_pkg, kabf_ctrl, kabf_dp.
//
// One sample in, one result out. After a sample is accepted, it passes through
// 17 steps on one shared 32x32 multiplier and adders and two divisions
// (start, 32+FRAC_BITS quotient bits on one bit-per-cycle divider, store),
// and o_valid rises in an output state that presents the result. The next
// sample is taken once the result is taken. Write configuration only while
// idle; writing initial_bias reloads bias.
module kalman_angle_bias_filter_core
    import kabf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_gyro_rate,
    input  logic signed [31:0]  i_measured_angle,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_angle_estimate,
    output logic signed [31:0]  o_corrected_rate,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    kabf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    kabf_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_idx        (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_gyro_rate      (i_gyro_rate),
        .i_measured_angle (i_measured_angle),
        .o_angle_estimate (o_angle_estimate),
        .o_corrected_rate (o_corrected_rate)
    );
endmodule

// File: src/kabf_checker.sv
// Port-level checks for the filter core, bound to the top level.
// Depends on nothing but the top level's ports.
module kabf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_angle_estimate,
    input logic [31:0] o_corrected_rate
);
    // No new item is taken while a result waits
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("item taken while result pending");

    // An accepted item never yields a result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !o_valid) else $error("result too early");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_angle_estimate)
                                  && $stable(o_corrected_rate)))
        else $error("stalled result changed");
endmodule

bind kalman_angle_bias_filter_core kabf_checker u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_angle_estimate (o_angle_estimate),
    .o_corrected_rate (o_corrected_rate)
);
